/* hw/rtl/htp_pkg.sv */
// ----------------------------------------------------------------------------
// Handheld timer prescaler package
// Shared types and constants for the prescaler, divider and timer logic.
// ----------------------------------------------------------------------------
`default_nettype none

package htp_pkg;

  localparam int unsigned CLK_W   = 5;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PRE_W   = 4;
  localparam int unsigned STAGE_W = 2;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [CLK_W-1:0]   CLK_MAX    = 5'd16;
  localparam logic [STAGE_W-1:0] STAGE_LAST = 2'd3;

  typedef enum logic [1:0] {
    RATE_DIV1024 = 2'd0,
    RATE_DIV16   = 2'd1,
    RATE_DIV64   = 2'd2,
    RATE_DIV256  = 2'd3
  } rate_sel_t;

  typedef enum logic {
    REG_RATE_SELECT  = 1'b0,
    REG_RELOAD_VALUE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    rate_sel_t        rate_select;
    logic [CNT_W-1:0] reload_value;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] timer_value;
    logic [CNT_W-1:0] divider_value;
    logic             timer_irq;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/htp_if.sv */
// ----------------------------------------------------------------------------
// Handheld timer prescaler channels
// Valid/ready channels for the clock advance items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface htp_in_if import htp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CLK_W-1:0] clock_count;

  modport source (output valid, output clock_count, input ready);
  modport sink   (input valid, input clock_count, output ready);
endinterface

interface htp_out_if import htp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] timer_value;
  logic [CNT_W-1:0] divider_value;
  logic             timer_irq;

  modport source (output valid, output timer_value, output divider_value,
                  output timer_irq, input ready);
  modport sink   (input valid, input timer_value, input divider_value,
                  input timer_irq, output ready);
endinterface

`default_nettype wire

/* hw/rtl/htp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Handheld timer prescaler configuration registers
// APB-style register file holding the rate select and the reload value.
// ----------------------------------------------------------------------------
`default_nettype none

module htp_cfg_regs import htp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  rate_sel_t        rate_select_r;
  logic [CNT_W-1:0] reload_value_r;
  reg_idx_t         reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_select_r  <= RATE_DIV1024;
      reload_value_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RATE_SELECT:  rate_select_r  <= rate_sel_t'(pwdata[1:0]);
        REG_RELOAD_VALUE: reload_value_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RATE_SELECT:  prdata = {{(DATA_W-2){1'b0}}, rate_select_r};
      REG_RELOAD_VALUE: prdata = {{(DATA_W-CNT_W){1'b0}}, reload_value_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.rate_select  = rate_select_r;
  assign cfg.reload_value = reload_value_r;

endmodule

`default_nettype wire

/* hw/rtl/htp_tick_core.sv */
// ----------------------------------------------------------------------------
// Handheld timer prescaler tick core
// Prescaler, divide-by-4 cascade, divider and timer state with the result
// of one item computed in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module htp_tick_core import htp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [CLK_W-1:0] clock_count,
  input  wire cfg_t             cfg,
  output result_t               res
);

  logic [PRE_W-1:0]   prescale_r, prescale_nxt;
  logic [STAGE_W-1:0] stage1_r, stage1_nxt;
  logic [STAGE_W-1:0] stage2_r, stage2_nxt;
  logic [STAGE_W-1:0] stage3_r, stage3_nxt;
  logic [CNT_W-1:0]   timer_r, timer_nxt;
  logic [CNT_W-1:0]   divider_r, divider_nxt;
  logic [CLK_W-1:0]   clk_sat;
  logic [CLK_W-1:0]   pre_sum;
  logic [CNT_W-1:0]   timer_inc;
  logic               t16, t64, t256, t1024;
  logic               sel;
  logic               ovf;

  always_comb begin
    clk_sat      = (clock_count > CLK_MAX) ? CLK_MAX : clock_count;
    pre_sum      = {1'b0, prescale_r} + clk_sat;
    t16          = pre_sum[CLK_W-1];
    prescale_nxt = pre_sum[PRE_W-1:0];

    t64   = t16 && (stage1_r == STAGE_LAST);
    t256  = t64 && (stage2_r == STAGE_LAST);
    t1024 = t256 && (stage3_r == STAGE_LAST);

    stage1_nxt  = t16  ? stage1_r + 2'd1 : stage1_r;
    stage2_nxt  = t64  ? stage2_r + 2'd1 : stage2_r;
    stage3_nxt  = t256 ? stage3_r + 2'd1 : stage3_r;
    divider_nxt = t256 ? divider_r + 8'd1 : divider_r;

    unique case (cfg.rate_select)
      RATE_DIV16:   sel = t16;
      RATE_DIV64:   sel = t64;
      RATE_DIV256:  sel = t256;
      RATE_DIV1024: sel = t1024;
      default:      sel = t1024;
    endcase

    timer_inc = timer_r + 8'd1;
    ovf       = sel && (timer_inc == '0);
    if (!sel) begin
      timer_nxt = timer_r;
    end else if (ovf) begin
      timer_nxt = cfg.reload_value;
    end else begin
      timer_nxt = timer_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
      stage1_r   <= '0;
      stage2_r   <= '0;
      stage3_r   <= '0;
      timer_r    <= '0;
      divider_r  <= '0;
    end else if (accept) begin
      prescale_r <= prescale_nxt;
      stage1_r   <= stage1_nxt;
      stage2_r   <= stage2_nxt;
      stage3_r   <= stage3_nxt;
      timer_r    <= timer_nxt;
      divider_r  <= divider_nxt;
    end
  end

  assign res.timer_value   = timer_nxt;
  assign res.divider_value = divider_nxt;
  assign res.timer_irq     = ovf;

  a_cascade: assert property (@(posedge clk) disable iff (!rst_n)
    t1024 |-> (t256 && t64 && t16))
    else $error("slow tick without all faster ticks");

  a_irq_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ovf) |=> (timer_r == $past(cfg.reload_value)))
    else $error("timer did not reload on overflow");

  a_divider_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ((divider_r == $past(divider_r)) ||
                (divider_r == 8'($past(divider_r) + 8'd1))))
    else $error("divider moved by more than one");

endmodule

`default_nettype wire

/* hw/rtl/htp_out_buf.sv */
// ----------------------------------------------------------------------------
// Handheld timer prescaler result buffer
// Two-entry result register that lets new items enter while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module htp_out_buf import htp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_res,
  output logic         full,
  output logic         valid,
  input  wire logic    ready,
  output result_t      head
);

  result_t    entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign pop   = valid && ready;
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("item pushed into full result buffer");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("result buffer pointers disagree with count");

endmodule

`default_nettype wire

/* hw/rtl/handheld_timer_prescaler_core.sv */
// ----------------------------------------------------------------------------
// Handheld timer prescaler
// Top level: prescaler, divider and timer with APB-style configuration.
// ----------------------------------------------------------------------------
// The block takes one clock advance item in every cycle unless the result
// buffer is full; the tick core does all counter updates for an item in a
// single pass, and the result is registered in the two-entry result buffer,
// which keeps the input open while a finished result waits on the output.
// The input stalls only when two results wait. Reset has no clearing pass.
`default_nettype none

module handheld_timer_prescaler_core import htp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  htp_in_if.sink                 in_if,
  htp_out_if.source              out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t    cfg;
  result_t res;
  result_t head;
  logic    full;
  logic    accept;

  assign in_if.ready = !full;
  assign accept      = in_if.valid && !full;

  htp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  htp_tick_core u_tick_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .clock_count (in_if.clock_count),
    .cfg         (cfg),
    .res         (res)
  );

  htp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_res (res),
    .full     (full),
    .valid    (out_if.valid),
    .ready    (out_if.ready),
    .head     (head)
  );

  assign out_if.timer_value   = head.timer_value;
  assign out_if.divider_value = head.divider_value;
  assign out_if.timer_irq     = head.timer_irq;

endmodule

`default_nettype wire
